@@ hdl/bpa_pkg.sv @@
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int NUM_PAGES_DEF = 65536;
    localparam int WORD_BITS     = 32;
    localparam int WORD_LOG      = 5;
    localparam int COUNT_W       = 17;
    localparam int PAGE_W        = 16;
    localparam int STATUS_W      = 2;
    localparam int CFG_AW        = 3;
    localparam int CFG_DW        = 32;

    localparam logic [COUNT_W-1:0]  USABLE_RESET = 17'd65536;
    localparam logic                REG_USABLE   = 1'b0;

    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OOM     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR_ROW,
        OP_LOAD,
        OP_FREE_SETUP,
        OP_ALLOC_SETUP,
        OP_SCAN_STEP,
        OP_WRAP,
        OP_OOM,
        OP_MARK_WRITE,
        OP_FINISH
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        op_t                 op;
        logic [STATUS_W-1:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic at_end;
        logic found;
        logic clr_last;
        logic req_free;
        logic cnt_zero;
        logic idx_zero;
    } dp_stat_t;

endpackage

@@ hdl/bpa_datapath.sv @@
`timescale 1ns / 1ps

module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic                s_req_type,
    input  logic [COUNT_W-1:0]  s_page_count,
    input  logic [PAGE_W-1:0]   s_page_index,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_wdata,
    output logic [COUNT_W-1:0]  cfg_rdata,
    output logic [STATUS_W-1:0] m_status,
    output logic [PAGE_W-1:0]   m_first_page,
    output logic [COUNT_W-1:0]  m_pages_in_use
);

    localparam int PLOG = $clog2(NUM_PAGES);
    localparam int XW   = (PLOG + 1 > 18) ? PLOG + 1 : 18;
    localparam int ROWS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [WORD_BITS-1:0] mem [ROWS];
    logic [WORD_BITS-1:0] rd_reg;

    logic                req_reg, req_next;
    logic [COUNT_W-1:0]  len_reg, len_next;
    logic [PAGE_W-1:0]   idx_reg, idx_next;
    logic [XW-1:0]       pos_reg, pos_next;
    logic [XW-1:0]       lim_reg, lim_next;
    logic [XW-1:0]       wrap_reg, wrap_next;
    logic [COUNT_W-1:0]  run_reg, run_next;
    logic [PAGE_W-1:0]   first_reg, first_next;
    logic [XW-1:0]       srch_reg, srch_next;
    logic [COUNT_W-1:0]  used_reg, used_next;
    logic [COUNT_W-1:0]  usable_reg, usable_next;
    logic [STATUS_W-1:0] mst_reg, mst_next;
    logic [PAGE_W-1:0]   mfp_reg, mfp_next;
    logic [COUNT_W-1:0]  miu_reg, miu_next;

    logic [RAW-1:0]       row_idx;
    logic [WORD_LOG-1:0]  offset;
    logic [WORD_LOG:0]    word_left;
    logic [XW-1:0]        span_left;
    logic [WORD_LOG:0]    span;
    logic [WORD_BITS-1:0] shifted;
    logic [WORD_BITS-1:0] inv;
    logic [WORD_LOG:0]    tz;
    logic [WORD_LOG:0]    step;
    logic [COUNT_W:0]     run_sum;
    logic                 found;
    logic [XW-1:0]        end_pos;
    logic [XW-1:0]        start_pos;
    logic [WORD_BITS-1:0] low_ones;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] wr_row;
    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wd;
    logic [XW-1:0]        lim_alloc;
    logic [XW-1:0]        free_sum;
    logic [XW-1:0]        free_end;
    logic [COUNT_W:0]     used_sum;
    logic [COUNT_W-1:0]   used_add;
    logic [COUNT_W-1:0]   used_sub;

    assign row_idx   = pos_reg[WORD_LOG +: RAW];
    assign offset    = pos_reg[WORD_LOG-1:0];
    assign word_left = (WORD_LOG + 1)'(WORD_BITS) - {1'b0, offset};
    assign span_left = lim_reg - pos_reg;
    assign span      = (span_left < XW'(word_left)) ? span_left[WORD_LOG:0] : word_left;

    // bits shifted in above the row read as used
    assign shifted = (rd_reg >> offset) | ~({WORD_BITS{1'b1}} >> offset);
    assign inv     = shifted[0] ? ~shifted : shifted;

    always_comb begin
        tz = (WORD_LOG + 1)'(WORD_BITS);
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (inv[i]) begin
                tz = (WORD_LOG + 1)'(i);
            end
        end
    end

    assign step      = (tz < span) ? tz : span;
    assign run_sum   = {1'b0, run_reg} + (COUNT_W + 1)'(step);
    assign found     = !shifted[0] && (run_sum >= {1'b0, len_reg});
    assign end_pos   = pos_reg + XW'(len_reg - run_reg);
    assign start_pos = end_pos - XW'(len_reg);

    assign low_ones = WORD_BITS'(((WORD_BITS + 1)'(1) << span) - (WORD_BITS + 1)'(1));
    assign mask     = low_ones << offset;
    assign wr_row   = req_reg ? (rd_reg & ~mask) : (rd_reg | mask);

    assign mem_we = (cmd.op == OP_CLR_ROW) || (cmd.op == OP_MARK_WRITE);
    assign mem_wd = (cmd.op == OP_CLR_ROW) ? {WORD_BITS{1'b1}} : wr_row;

    assign lim_alloc = (XW'(usable_reg) < XW'(NUM_PAGES)) ? XW'(usable_reg) : XW'(NUM_PAGES);
    assign free_sum  = XW'(idx_reg) + XW'(len_reg);
    assign free_end  = (free_sum < XW'(NUM_PAGES)) ? free_sum : XW'(NUM_PAGES);

    assign used_sum = {1'b0, used_reg} + {1'b0, len_reg};
    assign used_add = used_sum[COUNT_W] ? {COUNT_W{1'b1}} : used_sum[COUNT_W-1:0];
    assign used_sub = (used_reg > len_reg) ? (used_reg - len_reg) : '0;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[row_idx] <= mem_wd;
        end
        rd_reg <= mem[row_idx];
    end

    always_comb begin
        req_next    = req_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        lim_next    = lim_reg;
        wrap_next   = wrap_reg;
        run_next    = run_reg;
        first_next  = first_reg;
        srch_next   = srch_reg;
        used_next   = used_reg;
        mst_next    = mst_reg;
        mfp_next    = mfp_reg;
        miu_next    = miu_reg;
        usable_next = cfg_we ? cfg_wdata : usable_reg;
        case (cmd.op)
            OP_CLR_ROW: begin
                pos_next = pos_reg + XW'(WORD_BITS);
            end
            OP_LOAD: begin
                req_next   = s_req_type;
                len_next   = s_page_count;
                idx_next   = s_page_index;
                first_next = '0;
            end
            OP_FREE_SETUP: begin
                pos_next  = XW'(idx_reg);
                lim_next  = free_end;
                used_next = used_sub;
            end
            OP_ALLOC_SETUP: begin
                pos_next  = srch_reg;
                lim_next  = lim_alloc;
                wrap_next = (srch_reg < lim_alloc) ? srch_reg : lim_alloc;
                run_next  = '0;
            end
            OP_SCAN_STEP: begin
                if (found) begin
                    srch_next  = end_pos;
                    first_next = start_pos[PAGE_W-1:0];
                    pos_next   = start_pos;
                    lim_next   = end_pos;
                    used_next  = used_add;
                end else begin
                    pos_next = pos_reg + XW'(step);
                    run_next = shifted[0] ? '0 : run_sum[COUNT_W-1:0];
                end
            end
            OP_WRAP: begin
                pos_next = '0;
                lim_next = wrap_reg;
                run_next = '0;
            end
            OP_OOM: begin
                srch_next = wrap_reg;
            end
            OP_MARK_WRITE: begin
                pos_next = pos_reg + XW'(span);
            end
            OP_FINISH: begin
                mst_next = cmd.status;
                mfp_next = first_reg;
                miu_next = used_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            srch_reg   <= '0;
            used_reg   <= '0;
            usable_reg <= USABLE_RESET;
        end else begin
            pos_reg    <= pos_next;
            srch_reg   <= srch_next;
            used_reg   <= used_next;
            usable_reg <= usable_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        len_reg   <= len_next;
        idx_reg   <= idx_next;
        lim_reg   <= lim_next;
        wrap_reg  <= wrap_next;
        run_reg   <= run_next;
        first_reg <= first_next;
        mst_reg   <= mst_next;
        mfp_reg   <= mfp_next;
        miu_reg   <= miu_next;
    end

    assign stat.at_end   = (pos_reg >= lim_reg);
    assign stat.found    = found;
    assign stat.clr_last = (row_idx == RAW'(ROWS - 1));
    assign stat.req_free = req_reg;
    assign stat.cnt_zero = (len_reg == '0);
    assign stat.idx_zero = (idx_reg == '0);

    assign cfg_rdata      = usable_reg;
    assign m_status       = mst_reg;
    assign m_first_page   = mfp_reg;
    assign m_pages_in_use = miu_reg;

endmodule

@@ hdl/bpa_ctrl.sv @@
`timescale 1ns / 1ps

module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t              state_reg, state_next;
    logic                wrapped_reg, wrapped_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            wrapped_reg <= 1'b0;
            status_reg  <= STAT_DONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wrapped_reg <= wrapped_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        wrapped_next = wrapped_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd.op       = OP_NONE;
        cmd.status   = status_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.op = OP_CLR_ROW;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.cnt_zero || (stat.req_free && stat.idx_zero)) begin
                    status_next = STAT_IGNORED;
                    state_next  = ST_FINISH;
                end else if (stat.req_free) begin
                    cmd.op      = OP_FREE_SETUP;
                    status_next = STAT_DONE;
                    state_next  = ST_MARK_RD;
                end else begin
                    cmd.op       = OP_ALLOC_SETUP;
                    wrapped_next = 1'b0;
                    state_next   = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (stat.at_end) begin
                    if (!wrapped_reg) begin
                        cmd.op       = OP_WRAP;
                        wrapped_next = 1'b1;
                    end else begin
                        cmd.op      = OP_OOM;
                        status_next = STAT_OOM;
                        state_next  = ST_FINISH;
                    end
                end else begin
                    state_next = ST_SCAN_EV;
                end
            end
            ST_SCAN_EV: begin
                cmd.op = OP_SCAN_STEP;
                if (stat.found) begin
                    status_next = STAT_DONE;
                    state_next  = ST_MARK_RD;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MARK_RD: begin
                state_next = stat.at_end ? ST_FINISH : ST_MARK_WR;
            end
            ST_MARK_WR: begin
                cmd.op     = OP_MARK_WRITE;
                state_next = ST_MARK_RD;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = OP_FINISH;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

@@ hdl/bitmap_page_allocator_top.sv @@
`timescale 1ns / 1ps
// Next-fit page-frame allocator over a one-bit-per-page used map.
// Request channel (s_*): req_type 0 allocates page_count contiguous pages,
// 1 frees page_count pages from page_index. One result word per request on
// the m_* channel: status (done, out of memory, ignored), first page of an
// allocated run, and the used-page count after the request.
// Config: APB register usable_pages at address 0; write only while idle.
// Map is kept as 32-page rows in a single-port RAM. Ignored requests go
// straight to the result; a free reads and rewrites each row it touches;
// an alloc scans from where the last run ended, wrapping to page 0 once,
// then reads and rewrites each row of the run it found. A scan step
// covers one stretch of equal bits inside a row, so the scan time follows
// occupancy.
// Throughput is one request at a time; the next request is taken as soon as
// the current one is written to the output register.
// After reset the map is filled with used bits, one row per cycle;
// s_ready stays low until done.
// A stalled result holds the output register; the block may take one more
// request meanwhile and waits before posting its result.

module bitmap_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [CFG_DW-1:0]   pwdata,
    output logic [CFG_DW-1:0]   prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [COUNT_W-1:0]  s_page_count,
    input  logic [PAGE_W-1:0]   s_page_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [PAGE_W-1:0]   m_first_page,
    output logic [COUNT_W-1:0]  m_pages_in_use
);

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_rdata;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[CFG_AW-1] == REG_USABLE);
    assign prdata = (paddr[CFG_AW-1] == REG_USABLE) ? CFG_DW'(cfg_rdata) : '0;

    bpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bpa_datapath #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_req_type     (s_req_type),
        .s_page_count   (s_page_count),
        .s_page_index   (s_page_index),
        .cfg_we         (cfg_we),
        .cfg_wdata      (pwdata[COUNT_W-1:0]),
        .cfg_rdata      (cfg_rdata),
        .m_status       (m_status),
        .m_first_page   (m_first_page),
        .m_pages_in_use (m_pages_in_use)
    );

endmodule

@@ hdl/bpa_checker.sv @@
`timescale 1ns / 1ps

module bpa_checker
    import bpa_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [PAGE_W-1:0]   m_first_page,
    input logic [COUNT_W-1:0]  m_pages_in_use
);

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STAT_DONE || m_status == STAT_OOM ||
                     m_status == STAT_IGNORED))
        else $error("illegal result status");

    a_no_page_unless_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_DONE) |-> (m_first_page == '0))
        else $error("first page set on a failed or ignored request");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) &&
                                   $stable(m_first_page) && $stable(m_pages_in_use)))
        else $error("result word changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while another is in progress");

endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_first_page   (m_first_page),
    .m_pages_in_use (m_pages_in_use)
);
